@@ rtl/core/owm_pkg.sv @@
`default_nettype none

package owm_pkg;

  localparam int unsigned TickW     = 10;
  localparam int unsigned ByteW     = 8;
  localparam int unsigned BitIdxW   = 3;
  localparam int unsigned CfgIdxW   = 3;
  localparam int unsigned InDataW   = 16;
  localparam int unsigned OutDataW  = 16;

  // Register reset values, in ticks
  localparam logic [TickW-1:0] ResetLowRst        = 10'd480;
  localparam logic [TickW-1:0] PresenceWaitRst    = 10'd70;
  localparam logic [TickW-1:0] ResetRecoverRst    = 10'd410;
  localparam logic [TickW-1:0] Write0LowRst       = 10'd60;
  localparam logic [TickW-1:0] Write0RecoverRst   = 10'd10;
  localparam logic [TickW-1:0] ShortLowRst        = 10'd6;
  localparam logic [TickW-1:0] Write1RecoverRst   = 10'd64;
  localparam logic [TickW-1:0] ReadSampleWaitRst  = 10'd9;

  // Fixed release time after a read sample
  localparam logic [TickW-1:0] ReadRecoverUs      = 10'd55;

  typedef enum logic [1:0] {
    OpTick  = 2'd0,
    OpReset = 2'd1,
    OpWrite = 2'd2,
    OpRead  = 2'd3
  } opcode_e;

  typedef enum logic [CfgIdxW-1:0] {
    CfgResetLow       = 3'd0,
    CfgPresenceWait   = 3'd1,
    CfgResetRecover   = 3'd2,
    CfgWrite0Low      = 3'd3,
    CfgWrite0Recover  = 3'd4,
    CfgShortLow       = 3'd5,
    CfgWrite1Recover  = 3'd6,
    CfgReadSampleWait = 3'd7
  } cfg_idx_e;

  typedef struct packed {
    logic [TickW-1:0] reset_low_us;
    logic [TickW-1:0] presence_wait_us;
    logic [TickW-1:0] reset_recover_us;
    logic [TickW-1:0] write0_low_us;
    logic [TickW-1:0] write0_recover_us;
    logic [TickW-1:0] short_low_us;
    logic [TickW-1:0] write1_recover_us;
    logic [TickW-1:0] read_sample_wait_us;
  } cfg_t;

  typedef struct packed {
    logic             bus_level;
    logic [ByteW-1:0] data_byte;
    logic [1:0]       opcode;
  } in_t;

  typedef struct packed {
    logic             rejected;
    logic [ByteW-1:0] read_byte;
    logic             presence;
    logic             done_res;
    logic             busy_res;
    logic             drive_low;
  } out_t;

endpackage

`default_nettype wire

@@ rtl/core/one_wire_bus_master.sv @@
// 1-Wire bus master, standard speed.
// s_axis: one item per microsecond tick. tdata carries the opcode (tick only,
// reset with presence detect, write byte, read byte), the byte to write and the
// sampled line level. A command is taken only when the bus is idle; a command
// that arrives while one runs is dropped and flagged as rejected.
// m_axis: exactly one result item per input item, in order: drive_low for the
// line driver, busy, done on the last tick of a command, the presence flag,
// the last read byte and the reject flag.
// cfg: eight 10-bit tick counts, written at any edge with cfg_we_i high; write
// them only while no command runs. A zero count acts as one tick.
// Each item passes the input register, then the result register, which presents
// its result. Throughput: one item per cycle while m_axis_tready stays high;
// the sequencer state advances in a single pass per item.
// When the m_axis receiver stalls, the result register holds its item and the
// input register absorbs one more; then s_axis_tready drops until space frees.
// Reset empties both registers, clears the sequencer (bus idle, flags and read byte
// zero) and loads the standard timing values.
`default_nettype none

module one_wire_bus_master (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           s_axis_tvalid,
  output      logic                           s_axis_tready,
  // [1:0] opcode, [9:2] data_byte, [10] bus_level, [15:11] zero
  input  wire logic [owm_pkg::InDataW-1:0]    s_axis_tdata,
  output      logic                           m_axis_tvalid,
  input  wire logic                           m_axis_tready,
  // [0] drive_low, [1] busy_res, [2] done_res, [3] presence, [11:4] read_byte,
  // [12] rejected, [15:13] zero
  output      logic [owm_pkg::OutDataW-1:0]   m_axis_tdata,
  input  wire logic                           cfg_we_i,
  input  wire logic [owm_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  wire logic [owm_pkg::TickW-1:0]      cfg_wdata_i
);
  import owm_pkg::*;

  cfg_t  cfg;
  in_t   in_q;
  logic  in_valid_q;
  out_t  res;
  out_t  out_q;
  logic  out_valid_q;
  logic  adv;
  logic  step;

  assign adv           = !out_valid_q || m_axis_tready;
  assign step          = in_valid_q && adv;
  assign s_axis_tready = !in_valid_q || adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s_axis_tready) begin
        in_valid_q <= s_axis_tvalid;
      end
      if (adv) begin
        out_valid_q <= in_valid_q;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_q <= in_t'(s_axis_tdata[$bits(in_t)-1:0]);
    end
    if (step) begin
      out_q <= res;
    end
  end

  owm_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  owm_seq u_seq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .in_i   (in_q),
    .cfg_i  (cfg),
    .res_o  (res)
  );

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {(OutDataW - $bits(out_t))'(0), out_q};

endmodule

`default_nettype wire

@@ rtl/core/owm_cfg_regs.sv @@
`default_nettype none

module owm_cfg_regs (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         cfg_we_i,
  input  wire logic [owm_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [owm_pkg::TickW-1:0]    cfg_wdata_i,
  output owm_pkg::cfg_t                     cfg_o
);
  import owm_pkg::*;

  cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.reset_low_us        <= ResetLowRst;
      cfg_q.presence_wait_us    <= PresenceWaitRst;
      cfg_q.reset_recover_us    <= ResetRecoverRst;
      cfg_q.write0_low_us       <= Write0LowRst;
      cfg_q.write0_recover_us   <= Write0RecoverRst;
      cfg_q.short_low_us        <= ShortLowRst;
      cfg_q.write1_recover_us   <= Write1RecoverRst;
      cfg_q.read_sample_wait_us <= ReadSampleWaitRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CfgResetLow:       cfg_q.reset_low_us        <= cfg_wdata_i;
        CfgPresenceWait:   cfg_q.presence_wait_us    <= cfg_wdata_i;
        CfgResetRecover:   cfg_q.reset_recover_us    <= cfg_wdata_i;
        CfgWrite0Low:      cfg_q.write0_low_us       <= cfg_wdata_i;
        CfgWrite0Recover:  cfg_q.write0_recover_us   <= cfg_wdata_i;
        CfgShortLow:       cfg_q.short_low_us        <= cfg_wdata_i;
        CfgWrite1Recover:  cfg_q.write1_recover_us   <= cfg_wdata_i;
        CfgReadSampleWait: cfg_q.read_sample_wait_us <= cfg_wdata_i;
        default:           cfg_q.reset_low_us        <= cfg_q.reset_low_us;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

@@ rtl/core/owm_seq.sv @@
`default_nettype none

module owm_seq (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          step_i,
  input  wire owm_pkg::in_t  in_i,
  input  wire owm_pkg::cfg_t cfg_i,
  output owm_pkg::out_t      res_o
);
  import owm_pkg::*;

  typedef enum logic [2:0] {
    PhIdle    = 3'd0,
    PhRstLow  = 3'd1,
    PhRstWait = 3'd2,
    PhRstRec  = 3'd3,
    PhSlotLow = 3'd4,
    PhSlotRel = 3'd5,
    PhReadRec = 3'd6
  } phase_e;

  phase_e             phase_q, phase_d;
  logic [TickW-1:0]   ticks_q, ticks_d;
  logic [BitIdxW-1:0] bit_q, bit_d;
  opcode_e            kind_q, kind_d;
  logic [ByteW-1:0]   shift_q, shift_d;
  logic               pres_q, pres_d;
  logic [ByteW-1:0]   rbyte_q, rbyte_d;
  logic [TickW-1:0]   len;
  logic               cur_bit;
  logic               drive, busy, done, rej;

  function automatic logic [TickW-1:0] at_least_one(input logic [TickW-1:0] v);
    return (v == '0) ? TickW'(1) : v;
  endfunction

  always_comb begin
    phase_d = phase_q;
    ticks_d = ticks_q;
    bit_d   = bit_q;
    kind_d  = kind_q;
    shift_d = shift_q;
    pres_d  = pres_q;
    rbyte_d = rbyte_q;
    drive   = 1'b0;
    busy    = 1'b0;
    done    = 1'b0;
    rej     = 1'b0;
    len     = TickW'(1);
    cur_bit = 1'b0;

    // start a command on an idle bus; the start tick is the first tick of its first phase
    if (phase_q == PhIdle) begin
      if (opcode_e'(in_i.opcode) != OpTick) begin
        kind_d  = opcode_e'(in_i.opcode);
        ticks_d = '0;
        bit_d   = '0;
        if (opcode_e'(in_i.opcode) == OpReset) begin
          phase_d = PhRstLow;
        end else begin
          phase_d = PhSlotLow;
          shift_d = (opcode_e'(in_i.opcode) == OpWrite) ? in_i.data_byte : '0;
        end
      end
    end else if (opcode_e'(in_i.opcode) != OpTick) begin
      rej = 1'b1;
    end

    cur_bit = shift_d[bit_d];
    unique case (phase_d)
      PhRstLow:  len = at_least_one(cfg_i.reset_low_us);
      PhRstWait: len = at_least_one(cfg_i.presence_wait_us);
      PhRstRec:  len = at_least_one(cfg_i.reset_recover_us);
      PhSlotLow: len = (kind_d == OpWrite && !cur_bit) ? at_least_one(cfg_i.write0_low_us)
                                                       : at_least_one(cfg_i.short_low_us);
      PhSlotRel: begin
        if (kind_d == OpRead) begin
          len = at_least_one(cfg_i.read_sample_wait_us);
        end else begin
          len = cur_bit ? at_least_one(cfg_i.write1_recover_us)
                        : at_least_one(cfg_i.write0_recover_us);
        end
      end
      PhReadRec: len = ReadRecoverUs;
      default:   len = TickW'(1);
    endcase

    if (phase_d != PhIdle) begin
      busy  = 1'b1;
      drive = (phase_d == PhRstLow) || (phase_d == PhSlotLow);
      if ({1'b0, ticks_d} + (TickW+1)'(1) >= {1'b0, len}) begin
        ticks_d = '0;
        unique case (phase_d)
          PhRstLow:  phase_d = PhRstWait;
          PhRstWait: begin
            pres_d  = !in_i.bus_level;
            phase_d = PhRstRec;
          end
          PhRstRec: begin
            phase_d = PhIdle;
            done    = 1'b1;
          end
          PhSlotLow: phase_d = PhSlotRel;
          PhSlotRel, PhReadRec: begin
            if (phase_d == PhSlotRel && kind_d == OpRead) begin
              shift_d[bit_d] = shift_d[bit_d] | in_i.bus_level;
              phase_d        = PhReadRec;
            end else if (bit_d == BitIdxW'(ByteW-1)) begin
              // last slot of the byte
              if (kind_d == OpRead) begin
                rbyte_d = shift_d;
              end
              phase_d = PhIdle;
              bit_d   = '0;
              done    = 1'b1;
            end else begin
              bit_d   = bit_d + BitIdxW'(1);
              phase_d = PhSlotLow;
            end
          end
          default: begin
            phase_d = PhIdle;
            done    = 1'b1;
          end
        endcase
      end else begin
        ticks_d = ticks_d + TickW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhIdle;
      ticks_q <= '0;
      bit_q   <= '0;
      kind_q  <= OpTick;
      shift_q <= '0;
      pres_q  <= 1'b0;
      rbyte_q <= '0;
    end else if (step_i) begin
      phase_q <= phase_d;
      ticks_q <= ticks_d;
      bit_q   <= bit_d;
      kind_q  <= kind_d;
      shift_q <= shift_d;
      pres_q  <= pres_d;
      rbyte_q <= rbyte_d;
    end
  end

  assign res_o.drive_low = drive;
  assign res_o.busy_res  = busy;
  assign res_o.done_res  = done;
  assign res_o.presence  = pres_d;
  assign res_o.read_byte = rbyte_d;
  assign res_o.rejected  = rej;

  a_done_goes_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && done |=> phase_q == PhIdle)
    else $error("completed command left the sequencer busy");

  a_rej_needs_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rej |-> busy && phase_q != PhIdle)
    else $error("command rejected on an idle bus");

  a_bit_zero_outside_slots: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PhIdle || phase_q == PhRstLow || phase_q == PhRstWait ||
     phase_q == PhRstRec) |-> bit_q == '0)
    else $error("bit index left nonzero outside byte slots");

  a_idle_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !step_i |=> $stable(phase_q) && $stable(ticks_q) && $stable(rbyte_q))
    else $error("sequencer state moved without an item");

endmodule

`default_nettype wire
